// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, with and without reset qualification, used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk_i edge while rst_ni is high.
`define MACS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked at every rising clk_i edge, reset included.
`define MACS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/macs_pkg.sv =====
// ----------------------------------------------------------------------------
// macs_pkg
// Constants, codes and control types of the moving average crossover block.
// ----------------------------------------------------------------------------
package macs_pkg;

  localparam int HISTORY_DEPTH = 256;
  localparam int PRICE_BITS    = 32;

  localparam int PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int LEN_W  = 8;
  localparam int SUM_W  = PRICE_BITS + LEN_W;
  localparam int PROD_W = SUM_W + LEN_W;
  localparam int AC_W   = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;

  localparam int INT_W     = 8;
  localparam int FRAC_W    = 16;
  localparam int Q_W       = INT_W + FRAC_W;
  localparam int DIV_STEPS = Q_W;

  localparam int IN_PRICE_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [Q_W-1:0] Q_MAX = '1;

  localparam logic [1:0] MODE_REGIME = 2'd0;
  localparam logic [1:0] MODE_DROP   = 2'd1;
  localparam logic [1:0] MODE_GAIN   = 2'd2;

  localparam logic [1:0] DIR_FLAT  = 2'd0;
  localparam logic [1:0] DIR_LONG  = 2'd1;
  localparam logic [1:0] DIR_SHORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAGS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SSLOW_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SFAST_LEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS    = 3'd7;

  typedef struct packed {
    logic             accept;
    logic             scan_rd;
    logic             mul;
    logic             decide;
    logic             div_step;
    logic             load_out;
    logic [LEN_W-1:0] idx;
  } macs_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] kmax;
    logic             need_div;
  } macs_sts_t;

endpackage

// ===== sv/macs_if.sv =====
// ----------------------------------------------------------------------------
// macs_in_if / macs_out_if
// Valid/ready channels for price items and signal results.
// ----------------------------------------------------------------------------
interface macs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] close_price;
  logic signed [1:0] position_dir;

  modport source (output valid, output close_price, output position_dir, input ready);
  modport sink   (input valid, input close_price, input position_dir, output ready);
endinterface

interface macs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  direction;
  logic [23:0] confidence;
  logic [23:0] target_position;
  logic        exit_now;

  modport source (output valid, output direction, output confidence,
                  output target_position, output exit_now, input ready);
  modport sink   (input valid, input direction, input confidence,
                  input target_position, input exit_now, output ready);
endinterface

// ===== sv/macs_ram.sv =====
// ----------------------------------------------------------------------------
// macs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module macs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/macs_ctrl.sv =====
// ----------------------------------------------------------------------------
// macs_ctrl
// Sequencer: ring scan, cross products, decision, division, result handoff.
// ----------------------------------------------------------------------------
module macs_ctrl import macs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  macs_sts_t sts_i,
  output macs_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_FLUSH  = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.idx   = cnt_q;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (cnt_q == sts_i.kmax) begin
          state_d = S_FLUSH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FLUSH: begin
        cnt_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (cnt_q == LEN_W'(3)) begin
          state_d = S_DECIDE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        cnt_d        = '0;
        state_d      = sts_i.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == LEN_W'(DIV_STEPS - 1)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/macs_dp.sv =====
// ----------------------------------------------------------------------------
// macs_dp
// Datapath: config registers, ring pointers, window sums, cross products,
// crossing and threshold decision, Q8.16 restoring divider, result register.
// ----------------------------------------------------------------------------
module macs_dp import macs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  macs_cmd_t               cmd_i,
  output macs_sts_t               sts_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [IN_PRICE_W-1:0]   close_price_i,
  input  logic signed [1:0]       position_dir_i,
  output logic                    ram_we_o,
  output logic [PTR_W-1:0]        ram_waddr_o,
  output logic [PRICE_BITS-1:0]   ram_wdata_o,
  output logic [PTR_W-1:0]        ram_raddr_o,
  input  logic [PRICE_BITS-1:0]   ram_rdata_i,
  output logic [1:0]              direction_o,
  output logic [Q_W-1:0]          confidence_o,
  output logic [Q_W-1:0]          target_position_o,
  output logic                    exit_now_o
);

  // config
  logic [1:0]       mode_q, flags_q;
  logic [LEN_W-1:0] len_q [4];
  logic [Q_W-1:0]   thr_q, max_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_REGIME;
      flags_q   <= '0;
      len_q[0]  <= LEN_W'(5);
      len_q[1]  <= LEN_W'(20);
      len_q[2]  <= LEN_W'(5);
      len_q[3]  <= LEN_W'(20);
      thr_q     <= Q_W'(3277);
      max_pos_q <= Q_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:      mode_q    <= cfg_data_i[1:0];
        CFG_FLAGS:     flags_q   <= cfg_data_i[1:0];
        CFG_SLOW_LEN:  len_q[1]  <= cfg_data_i[LEN_W-1:0];
        CFG_FAST_LEN:  len_q[0]  <= cfg_data_i[LEN_W-1:0];
        CFG_SSLOW_LEN: len_q[3]  <= cfg_data_i[LEN_W-1:0];
        CFG_SFAST_LEN: len_q[2]  <= cfg_data_i[LEN_W-1:0];
        CFG_THRESHOLD: thr_q     <= cfg_data_i[Q_W-1:0];
        CFG_MAX_POS:   max_pos_q <= cfg_data_i[Q_W-1:0];
        default: ;
      endcase
    end
  end

  // ring pointers
  logic [PTR_W-1:0] wptr_q;
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      wptr_q <= (wptr_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (count_q < CNT_W'(HISTORY_DEPTH)) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  logic [PRICE_BITS-1:0] price_in;
  assign price_in    = PRICE_BITS'(close_price_i);
  assign ram_we_o    = cmd_i.accept;
  assign ram_waddr_o = wptr_q;
  assign ram_wdata_o = price_in;

  // read address: newest entry minus age
  logic [AC_W-1:0] age_ext, wp_ext, raddr_full;
  always_comb begin
    age_ext = AC_W'(cmd_i.idx) + AC_W'(1);
    wp_ext  = AC_W'(wptr_q);
    if (wp_ext >= age_ext) begin
      raddr_full = wp_ext - age_ext;
    end else begin
      raddr_full = wp_ext + AC_W'(HISTORY_DEPTH) - age_ext;
    end
  end
  assign ram_raddr_o = PTR_W'(raddr_full);

  // scan limit
  logic [LEN_W-1:0] max01, max23, maxlen, kmax_c;
  logic [CNT_W-1:0] cnt_m1;
  logic             need_div_c;
  always_comb begin
    max01  = (len_q[0] > len_q[1]) ? len_q[0] : len_q[1];
    max23  = (len_q[2] > len_q[3]) ? len_q[2] : len_q[3];
    maxlen = (max01 > max23) ? max01 : max23;
    cnt_m1 = count_q - 1'b1;
    kmax_c = (cnt_m1 < CNT_W'(maxlen)) ? LEN_W'(cnt_m1) : maxlen;
  end

  assign sts_o = '{kmax: kmax_c, need_div: need_div_c};

  // item capture and window accumulation
  logic [PRICE_BITS-1:0] price_q, lb_price_q;
  logic signed [1:0]     pd_q;
  logic                  acc_v_q;
  logic [LEN_W-1:0]      age_q;
  logic [SUM_W-1:0]      now_q [4];
  logic [SUM_W-1:0]      prev_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_v_q <= 1'b0;
    end else begin
      acc_v_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      price_q <= price_in;
      pd_q    <= position_dir_i;
      for (int j = 0; j < 4; j++) begin
        now_q[j]  <= '0;
        prev_q[j] <= '0;
      end
    end else if (acc_v_q) begin
      for (int j = 0; j < 4; j++) begin
        if (age_q < len_q[j]) begin
          now_q[j] <= now_q[j] + SUM_W'(ram_rdata_i);
        end
        if (age_q != '0 && age_q <= len_q[j]) begin
          prev_q[j] <= prev_q[j] + SUM_W'(ram_rdata_i);
        end
      end
      if (age_q == len_q[1]) begin
        lb_price_q <= ram_rdata_i;
      end
    end
    if (cmd_i.scan_rd) begin
      age_q <= cmd_i.idx;
    end
  end

  // cross products, two multipliers over four steps
  logic [SUM_W-1:0]  mx, my;
  logic [LEN_W-1:0]  mlx, mly;
  logic [PROD_W-1:0] pa_q [4];
  logic [PROD_W-1:0] pb_q [4];

  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0: begin mx = now_q[0];  my = now_q[1];  mly = len_q[1]; mlx = len_q[0]; end
      2'd1: begin mx = prev_q[0]; my = prev_q[1]; mly = len_q[1]; mlx = len_q[0]; end
      2'd2: begin mx = now_q[3];  my = now_q[2];  mly = len_q[2]; mlx = len_q[3]; end
      default: begin mx = prev_q[3]; my = prev_q[2]; mly = len_q[2]; mlx = len_q[3]; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      pa_q[cmd_i.idx[1:0]] <= PROD_W'(mx) * PROD_W'(mly);
      pb_q[cmd_i.idx[1:0]] <= PROD_W'(my) * PROD_W'(mlx);
    end
  end

  // decision
  logic [3:0]        now_ok, prev_ok;
  logic              long_x, short_x, lb_ok;
  logic [1:0]        d_dir;
  logic              d_exit, d_thr, d_div, d_sat;
  logic [PROD_W-1:0] d_num, d_den;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      now_ok[j]  = (len_q[j] != '0) && (CNT_W'(len_q[j]) <= count_q) && (now_q[j] != '0);
      prev_ok[j] = (len_q[j] != '0) && (CNT_W'(len_q[j]) < count_q) && (prev_q[j] != '0);
    end
    long_x  = (&now_ok[1:0]) && (&prev_ok[1:0]) && !(pa_q[1] > pb_q[1]) && (pa_q[0] > pb_q[0]);
    short_x = flags_q[0] && (&now_ok[3:2]) && (&prev_ok[3:2]) &&
              !(pa_q[3] > pb_q[3]) && (pa_q[2] > pb_q[2]);
    lb_ok   = CNT_W'(len_q[1]) < count_q;
    d_dir   = DIR_FLAT;
    d_exit  = 1'b0;
    d_thr   = 1'b0;
    d_div   = 1'b0;
    d_num   = '0;
    d_den   = '0;
    case (mode_q)
      MODE_REGIME: begin
        if (long_x) begin
          d_dir = DIR_LONG;
          d_div = 1'b1;
          d_num = pa_q[0] - pb_q[0];
          d_den = pb_q[0];
        end else if (short_x) begin
          d_dir = DIR_SHORT;
          d_div = 1'b1;
          d_num = pa_q[2] - pb_q[2];
          d_den = pa_q[2];
        end
        if (flags_q[1]) begin
          if (pd_q == 2'sd1) begin
            d_exit = (&now_ok[1:0]) && (pb_q[0] > pa_q[0]);
          end else if (pd_q[1]) begin
            d_exit = (&now_ok[3:2]) && (pb_q[2] > pa_q[2]);
          end
        end
      end
      MODE_DROP, MODE_GAIN: begin
        if (lb_ok && lb_price_q != '0) begin
          if (mode_q == MODE_DROP && price_q <= lb_price_q) begin
            d_dir = DIR_LONG;
            d_thr = 1'b1;
            d_div = 1'b1;
            d_num = PROD_W'(lb_price_q - price_q);
            d_den = PROD_W'(lb_price_q);
          end else if (mode_q == MODE_GAIN && price_q >= lb_price_q) begin
            d_dir = DIR_LONG;
            d_thr = 1'b1;
            d_div = 1'b1;
            d_num = PROD_W'(price_q - lb_price_q);
            d_den = PROD_W'(lb_price_q);
          end
        end
      end
      default: ;
    endcase
    d_sat      = (PROD_W + INT_W)'(d_num) >= {d_den, INT_W'(0)};
    need_div_c = d_div && !d_sat;
  end

  // restoring divider: floor(num * 2^16 / den), 24 quotient bits
  logic [1:0]        dir_q;
  logic              exit_q, thr_hit_q;
  logic [PROD_W-1:0] den_q, rem_q;
  logic [Q_W-1:0]    xl_q, quo_q;
  logic [PROD_W:0]   trial;
  logic              ge;

  assign trial = {rem_q, xl_q[Q_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      dir_q     <= d_dir;
      exit_q    <= d_exit;
      thr_hit_q <= d_thr;
      den_q     <= d_den;
      rem_q     <= d_num >> INT_W;
      xl_q      <= {d_num[INT_W-1:0], FRAC_W'(0)};
      quo_q     <= (d_div && d_sat) ? Q_MAX : '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? PROD_W'(trial - {1'b0, den_q}) : PROD_W'(trial);
      xl_q  <= {xl_q[Q_W-2:0], 1'b0};
      quo_q <= {quo_q[Q_W-2:0], ge};
    end
  end

  // result register
  logic           below;
  logic [1:0]     out_dir_q;
  logic [Q_W-1:0] out_conf_q, out_tp_q;
  logic           out_exit_q;

  assign below = thr_hit_q && (quo_q < thr_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_dir_q  <= below ? DIR_FLAT : dir_q;
      out_conf_q <= below ? '0 : quo_q;
      out_tp_q   <= max_pos_q;
      out_exit_q <= exit_q;
    end
  end

  assign direction_o       = out_dir_q;
  assign confidence_o      = out_conf_q;
  assign target_position_o = out_tp_q;
  assign exit_now_o        = out_exit_q;

endmodule

// ===== sv/moving_average_crossover_signal.sv =====
// ----------------------------------------------------------------------------
// moving_average_crossover_signal
// One closing price in, one trading signal out. Each item is written to a
// 256-entry price ring, then the ring is read back once per cycle from the
// newest price over the longest configured window (clipped to the stored
// history), building the current and previous sums of all four windows in one
// pass. Shared cross multiplication, a decision step and, when needed, a
// restoring division follow. The time an item takes is set by the single
// ring read port and the one-bit-per-cycle divider. A finished result waits
// in an output register while the next price is already taken. No clearing
// pass after reset.
// ----------------------------------------------------------------------------
module moving_average_crossover_signal import macs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  macs_in_if.sink               in_s,
  macs_out_if.source            out_s,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  macs_cmd_t             cmd;
  macs_sts_t             sts;
  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr, ram_raddr;
  logic [PRICE_BITS-1:0] ram_wdata, ram_rdata;

  macs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_s.valid),
    .out_ready_i (out_s.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  macs_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .close_price_i     (in_s.close_price),
    .position_dir_i    (in_s.position_dir),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .direction_o       (out_s.direction),
    .confidence_o      (out_s.confidence),
    .target_position_o (out_s.target_position),
    .exit_now_o        (out_s.exit_now)
  );

  macs_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== sv/macs_chk.sv =====
// ----------------------------------------------------------------------------
// macs_chk
// Port-level checks of the crossover block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module macs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  direction_i,
  input logic [23:0] confidence_i
);

  // one transaction in flight: input closes right after an accept
  `MACS_ASSERT(a_one_in_flight, (in_valid_i && in_ready_i) |=> !in_ready_i, "second transaction taken while busy")
  `MACS_ASSERT(a_flat_zero_conf, (out_valid_i && direction_i == 2'd0) |-> (confidence_i == 24'd0), "flat result with nonzero confidence")
  `MACS_ASSERT(a_dir_legal, out_valid_i |-> (direction_i != 2'd3), "undefined direction code")
  `MACS_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(confidence_i) && $stable(direction_i)), "stalled result changed")

endmodule

bind moving_average_crossover_signal macs_chk u_macs_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_s.valid),
  .in_ready_i   (in_s.ready),
  .out_valid_i  (out_s.valid),
  .out_ready_i  (out_s.ready),
  .direction_i  (out_s.direction),
  .confidence_i (out_s.confidence)
);
